@@ hdl/lsnr_pkg.sv @@
// Shared types and codes for the LIFO stack with negative removal.
package lsnr_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned RSP_W   = 48;

   typedef enum logic [1:0] {
      MODE_PUSH     = 2'd0,
      MODE_POP      = 2'd1,
      MODE_DROP_NEG = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_NO_NEG = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // shift command broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } cmd_type;

   // search / close token handed from one cell to the next
   typedef struct packed {
      logic srch;
      logic clos;
   } tok_type;

   // per-cell result of a token visit
   typedef struct packed {
      logic miss;
      logic done;
   } rpt_type;

endpackage

@@ hdl/lsnr_cell.sv @@
// One stack slot: holds a word, shifts with its neighbors, carries the search token.
module lsnr_cell #(
   parameter int CNT_W = 7,
   parameter int IDX   = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lsnr_pkg::cmd_type             cmd,
   input  logic [CNT_W-1:0]              cnt,
   input  logic [lsnr_pkg::WORD_W-1:0]   up_val,
   input  logic [lsnr_pkg::WORD_W-1:0]   dn_val,
   input  lsnr_pkg::tok_type             tok_in,
   output logic [lsnr_pkg::WORD_W-1:0]   val_out,
   output lsnr_pkg::tok_type             tok_out,
   output lsnr_pkg::rpt_type             rpt
);

   localparam logic [CNT_W:0] IDX_P  = (CNT_W+1)'(IDX);
   localparam logic [CNT_W:0] NEXT_P = (CNT_W+1)'(IDX + 1);

   logic [lsnr_pkg::WORD_W-1:0] val_ff, val_in;
   lsnr_pkg::tok_type           tok_ff;
   logic                        here_vld, dn_vld;

   assign here_vld = IDX_P  < {1'b0, cnt};
   assign dn_vld   = NEXT_P < {1'b0, cnt};

   always_comb begin
      val_in  = val_ff;
      tok_out = '0;
      rpt     = '0;
      if (cmd.push) begin
         val_in = up_val;
      end else if (cmd.pop) begin
         val_in = dn_val;
      end
      if (tok_ff.srch) begin
         if (!here_vld) begin
            rpt.miss = 1'b1;
         end else if (val_ff[lsnr_pkg::WORD_W-1]) begin
            // first negative from the top: start closing the gap here
            val_in = dn_val;
            if (dn_vld) begin
               tok_out.clos = 1'b1;
            end else begin
               rpt.done = 1'b1;
            end
         end else begin
            tok_out.srch = 1'b1;
         end
      end
      if (tok_ff.clos) begin
         val_in = dn_val;
         if (dn_vld) begin
            tok_out.clos = 1'b1;
         end else begin
            rpt.done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign val_out = val_ff;

endmodule

@@ hdl/lifo_stack_with_negative_removal.sv @@
// Top level: bounded LIFO stack built as a chain of cells, top of stack in cell 0.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid / req_tready | tuser: mode; tdata: push_value
//  rsp     | out | rsp_tvalid / rsp_tready | tdata: popped_value, status, entry_count
//
// Push shifts every cell away from the top and pop toward it, in the cycle the
// request is taken; clear only resets the fill count. For remove-negative a
// token walks the chain one cell a cycle, searching down from the top, then
// closes the gap by pulling each lower word up as it passes. Reset clears the
// fill count, the state, the output valid flag and the cell tokens; stored
// words and result fields keep whatever they held. A stalled result waits in the
// output register and the next item is taken in the cycle it drains.
module lifo_stack_with_negative_removal #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,   // [31:0] push_value
   input  logic [1:0]                 req_tuser,   // [1:0] mode
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [lsnr_pkg::RSP_W-1:0] rsp_tdata    // [31:0] popped_value,
                                                   // [33:32] status,
                                                   // [40:34] entry_count, rest zero
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int W     = lsnr_pkg::WORD_W;
   localparam int CW    = lsnr_pkg::COUNT_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

   lsnr_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic                    rsp_vld_ff, rsp_vld_in;
   logic [W-1:0]            rsp_val_ff, rsp_val_in;
   lsnr_pkg::status_type    rsp_st_ff, rsp_st_in;
   logic [CW-1:0]           rsp_cnt_ff, rsp_cnt_in;

   lsnr_pkg::mode_type  mode;
   logic                accept, start, miss_any, done_any, rsp_load;
   lsnr_pkg::cmd_type   cmd;

   logic [W-1:0]        cell_val [STACK_DEPTH];
   lsnr_pkg::tok_type   tok      [STACK_DEPTH+1];
   lsnr_pkg::rpt_type   rpt      [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] miss_vec, done_vec;

   logic [CNT_W+CW-1:0] cnt_ext;

   assign mode   = lsnr_pkg::mode_type'(req_tuser);
   assign accept = req_tvalid && req_tready;

   // ---------------- cell chain ----------------
   assign tok[0].srch = start;
   assign tok[0].clos = 1'b0;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [W-1:0] up_v, dn_v;
      if (i == 0) begin : g_top
         assign up_v = req_tdata;
      end else begin : g_mid
         assign up_v = cell_val[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
         assign dn_v = '0;
      end else begin : g_up
         assign dn_v = cell_val[i+1];
      end
      lsnr_cell #(
         .CNT_W (CNT_W),
         .IDX   (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .cnt     (cnt_ff),
         .up_val  (up_v),
         .dn_val  (dn_v),
         .tok_in  (tok[i]),
         .val_out (cell_val[i]),
         .tok_out (tok[i+1]),
         .rpt     (rpt[i])
      );
      assign miss_vec[i] = rpt[i].miss;
      assign done_vec[i] = rpt[i].done;
   end

   // search token falling off the bottom means no negative word was found
   assign miss_any = (|miss_vec) || tok[STACK_DEPTH].srch;
   assign done_any = |done_vec;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsnr_pkg::ST_IDLE: begin
            if (start) state_in = lsnr_pkg::ST_SCAN;
         end
         lsnr_pkg::ST_SCAN: begin
            if (miss_any || done_any) state_in = lsnr_pkg::ST_IDLE;
         end
         default: state_in = lsnr_pkg::ST_IDLE;
      endcase
   end

   // ---------------- outputs / datapath control ----------------
   always_comb begin
      req_tready = (state_ff == lsnr_pkg::ST_IDLE) && (!rsp_vld_ff || rsp_tready);
      cmd        = '0;
      start      = 1'b0;
      rsp_load   = 1'b0;
      cnt_in     = cnt_ff;
      rsp_val_in = '0;
      rsp_st_in  = lsnr_pkg::STAT_OK;
      if (state_ff == lsnr_pkg::ST_IDLE) begin
         if (accept) begin
            rsp_load = 1'b1;
            unique case (mode)
               lsnr_pkg::MODE_PUSH: begin
                  if (cnt_ff >= DEPTH_C) begin
                     rsp_st_in = lsnr_pkg::STAT_FULL;
                  end else begin
                     cmd.push = 1'b1;
                     cnt_in   = cnt_ff + CNT_W'(1);
                  end
               end
               lsnr_pkg::MODE_POP: begin
                  if (cnt_ff == '0) begin
                     rsp_st_in = lsnr_pkg::STAT_EMPTY;
                  end else begin
                     cmd.pop    = 1'b1;
                     cnt_in     = cnt_ff - CNT_W'(1);
                     rsp_val_in = cell_val[0];
                  end
               end
               lsnr_pkg::MODE_DROP_NEG: begin
                  if (cnt_ff == '0) begin
                     rsp_st_in = lsnr_pkg::STAT_EMPTY;
                  end else begin
                     // result comes when the token finishes its walk
                     start    = 1'b1;
                     rsp_load = 1'b0;
                  end
               end
               lsnr_pkg::MODE_CLEAR: begin
                  cnt_in = '0;
               end
               default: ;
            endcase
         end
      end else begin
         if (done_any) begin
            rsp_load = 1'b1;
            cnt_in   = cnt_ff - CNT_W'(1);
         end else if (miss_any) begin
            rsp_load  = 1'b1;
            rsp_st_in = lsnr_pkg::STAT_NO_NEG;
         end
      end
      rsp_vld_in = rsp_load || (rsp_vld_ff && !rsp_tready);
   end

   // count reported masked to its field width
   assign cnt_ext    = {{CW{1'b0}}, cnt_in};
   assign rsp_cnt_in = cnt_ext[CW-1:0];

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_val_ff <= rsp_val_in;
         rsp_st_ff  <= rsp_st_in;
         rsp_cnt_ff <= rsp_cnt_in;
      end
      if (reset) begin
         state_ff   <= lsnr_pkg::ST_IDLE;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(lsnr_pkg::RSP_W - W - 2 - CW){1'b0}},
                        rsp_cnt_ff, rsp_st_ff, rsp_val_ff};

endmodule
